>>> hw/rtl/bra_pkg.sv
// Shared types and constants for the bitmap run allocator.
`default_nettype none

package bra_pkg;

  // Command codes
  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_e;

  // Result status codes
  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_NOSPACE = 2'd1,
    STAT_RANGE   = 2'd2
  } status_e;

  // Pool select codes
  localparam logic [1:0] POOL_VIEW    = 2'd0;
  localparam logic [1:0] POOL_TARGET  = 2'd1;
  localparam logic [1:0] POOL_DEPTH   = 2'd2;
  localparam logic [1:0] POOL_SAMPLER = 2'd3;

  // Bitmap word geometry: one RAM word holds WordBits slot flags
  localparam int unsigned WordBits    = 16;
  localparam int unsigned WordIdxBits = 4;

  // Request as classified by the front end
  typedef struct packed {
    cmd_e        cmd;
    logic [1:0]  pool;
    logic [9:0]  range_start;
    logic [10:0] run_length;
    logic        bad_range;
  } req_t;

  // Result item
  typedef struct packed {
    status_e    status;
    logic [9:0] granted_start;
  } rsp_t;

endpackage

`default_nettype wire

>>> hw/rtl/bra_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none

module bra_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 4
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   wr_en_i,
  input  wire logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] wr_addr_i,
  input  wire logic [Width-1:0]                       wr_data_i,
  input  wire logic                                   rd_en_i,
  input  wire logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] rd_addr_i,
  output logic      [Width-1:0]                       rd_data_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/bra_front.sv
// Front end: takes commands off the input stream and flags bad ranges.
`default_nettype none

module bra_front #(
  parameter int unsigned VIEW_SLOTS    = 1024,
  parameter int unsigned TARGET_SLOTS  = 256,
  parameter int unsigned DEPTH_SLOTS   = 256,
  parameter int unsigned SAMPLER_SLOTS = 256
) (
  input  wire logic          s_tvalid_i,
  output logic               s_tready_o,
  input  wire logic [23:0]   s_tdata_i,   // [9:0] range_start, [20:10] run_length
  input  wire logic [2:0]    s_tuser_i,   // [0] command, [2:1] pool
  input  wire logic          clearing_i,
  input  wire logic          q_full_i,
  output logic               push_o,
  output bra_pkg::req_t      req_o
);

  import bra_pkg::*;

  localparam int unsigned MaxAB    = VIEW_SLOTS > TARGET_SLOTS ? VIEW_SLOTS : TARGET_SLOTS;
  localparam int unsigned MaxCD    = DEPTH_SLOTS > SAMPLER_SLOTS ? DEPTH_SLOTS : SAMPLER_SLOTS;
  localparam int unsigned MaxSlots = MaxAB > MaxCD ? MaxAB : MaxCD;
  localparam int unsigned SW0      = $clog2(MaxSlots + 1);
  localparam int unsigned SW       = SW0 > 5 ? SW0 : 5;
  localparam int unsigned NW       = (SW > 11 ? SW : 11) + 1;

  logic [NW-1:0] pool_size;
  logic [NW-1:0] range_end;

  // Size of the selected pool
  always_comb begin
    case (s_tuser_i[2:1])
      POOL_VIEW:   pool_size = NW'(VIEW_SLOTS);
      POOL_TARGET: pool_size = NW'(TARGET_SLOTS);
      POOL_DEPTH:  pool_size = NW'(DEPTH_SLOTS);
      default:     pool_size = NW'(SAMPLER_SLOTS);
    endcase
  end

  assign range_end = NW'(s_tdata_i[9:0]) + NW'(s_tdata_i[20:10]);

  // Decode and classify; items are held off while the bitmaps are cleared
  always_comb begin
    req_o.cmd         = cmd_e'(s_tuser_i[0]);
    req_o.pool        = s_tuser_i[2:1];
    req_o.range_start = s_tdata_i[9:0];
    req_o.run_length  = s_tdata_i[20:10];
    req_o.bad_range   = (s_tdata_i[20:10] == 11'd0) ||
                        ((cmd_e'(s_tuser_i[0]) == CMD_FREE) && (range_end > pool_size));
  end

  assign s_tready_o = !clearing_i && !q_full_i;
  assign push_o     = s_tvalid_i && s_tready_o;

endmodule

`default_nettype wire

>>> hw/rtl/bra_queue.sv
// Two-entry request queue between front end and back end.
`default_nettype none

module bra_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  bra_pkg::req_t      req_i,
  output logic               full_o,
  output logic               valid_o,
  output bra_pkg::req_t      req_o,
  input  wire logic          pop_i
);

  import bra_pkg::*;

  req_t       entry_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;

  assign full_o  = count_q == 2'd2;
  assign valid_o = count_q != 2'd0;
  assign req_o   = entry_q[rd_ptr_q];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_d = push_i ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i ? !rd_ptr_q : rd_ptr_q;
    count_d  = count_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= req_i;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/bra_back.sv
// Back end: bitmap RAM, cursors, run search, range marking and result register.
`default_nettype none

module bra_back #(
  parameter int unsigned VIEW_SLOTS    = 1024,
  parameter int unsigned TARGET_SLOTS  = 256,
  parameter int unsigned DEPTH_SLOTS   = 256,
  parameter int unsigned SAMPLER_SLOTS = 256
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          req_valid_i,
  input  bra_pkg::req_t      req_i,
  output logic               req_pop_o,
  output logic               clearing_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output bra_pkg::rsp_t      out_rsp_o
);

  import bra_pkg::*;

  localparam int unsigned MaxAB    = VIEW_SLOTS > TARGET_SLOTS ? VIEW_SLOTS : TARGET_SLOTS;
  localparam int unsigned MaxCD    = DEPTH_SLOTS > SAMPLER_SLOTS ? DEPTH_SLOTS : SAMPLER_SLOTS;
  localparam int unsigned MaxSlots = MaxAB > MaxCD ? MaxAB : MaxCD;
  localparam int unsigned SW0      = $clog2(MaxSlots + 1);
  localparam int unsigned SW       = SW0 > 5 ? SW0 : 5;
  localparam int unsigned NW       = (SW > 11 ? SW : 11) + 1;

  // Word layout of the four bitmaps in one RAM
  localparam int unsigned ViewWords    = (VIEW_SLOTS + WordBits - 1) / WordBits;
  localparam int unsigned TargetWords  = (TARGET_SLOTS + WordBits - 1) / WordBits;
  localparam int unsigned DepthWords   = (DEPTH_SLOTS + WordBits - 1) / WordBits;
  localparam int unsigned SamplerWords = (SAMPLER_SLOTS + WordBits - 1) / WordBits;
  localparam int unsigned TargetBase   = ViewWords;
  localparam int unsigned DepthBase    = TargetBase + TargetWords;
  localparam int unsigned SamplerBase  = DepthBase + DepthWords;
  localparam int unsigned TotalWords   = SamplerBase + SamplerWords;
  localparam int unsigned AW           = $clog2(TotalWords);

  // Valid slots in each pool's last word, zero when the word is full
  localparam logic [WordIdxBits-1:0] ViewRem    = WordIdxBits'(VIEW_SLOTS % WordBits);
  localparam logic [WordIdxBits-1:0] TargetRem  = WordIdxBits'(TARGET_SLOTS % WordBits);
  localparam logic [WordIdxBits-1:0] DepthRem   = WordIdxBits'(DEPTH_SLOTS % WordBits);
  localparam logic [WordIdxBits-1:0] SamplerRem = WordIdxBits'(SAMPLER_SLOTS % WordBits);

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_SCAN  = 5'b00100,
    S_MARK  = 5'b01000,
    S_RESP  = 5'b10000
  } state_e;

  function automatic logic [NW-1:0] size_of(input logic [1:0] p);
    case (p)
      POOL_VIEW:   return NW'(VIEW_SLOTS);
      POOL_TARGET: return NW'(TARGET_SLOTS);
      POOL_DEPTH:  return NW'(DEPTH_SLOTS);
      default:     return NW'(SAMPLER_SLOTS);
    endcase
  endfunction

  function automatic logic [AW-1:0] base_of(input logic [1:0] p);
    case (p)
      POOL_VIEW:   return AW'(0);
      POOL_TARGET: return AW'(TargetBase);
      POOL_DEPTH:  return AW'(DepthBase);
      default:     return AW'(SamplerBase);
    endcase
  endfunction

  function automatic logic [AW-1:0] last_word_of(input logic [1:0] p);
    case (p)
      POOL_VIEW:   return AW'(ViewWords - 1);
      POOL_TARGET: return AW'(TargetWords - 1);
      POOL_DEPTH:  return AW'(DepthWords - 1);
      default:     return AW'(SamplerWords - 1);
    endcase
  endfunction

  function automatic logic [WordIdxBits-1:0] rem_of(input logic [1:0] p);
    case (p)
      POOL_VIEW:   return ViewRem;
      POOL_TARGET: return TargetRem;
      POOL_DEPTH:  return DepthRem;
      default:     return SamplerRem;
    endcase
  endfunction

  state_e          state_q, state_d;
  logic [AW-1:0]   clr_q, clr_d;
  logic [SW-1:0]   cursor_q [4];
  logic [SW-1:0]   cursor_d [4];
  cmd_e            cmd_q, cmd_d;
  logic [1:0]      pool_q, pool_d;
  logic [10:0]     len_q, len_d;
  logic [SW-1:0]   cur_q, cur_d;
  logic [NW-1:0]   run_q, run_d;
  logic [AW-1:0]   issue_q, issue_d;
  logic            iss_on_q, iss_on_d;
  logic [AW-1:0]   eval_q, eval_d;
  logic            vld_q, vld_d;
  logic [AW-1:0]   lim_q, lim_d;
  logic [SW-1:0]   start_q, start_d;
  logic [SW-1:0]   end_q, end_d;
  rsp_t            res_q, res_d;
  logic            out_vld_q, out_vld_d;
  rsp_t            out_q, out_d;

  // RAM port signals
  logic                ram_wr_en;
  logic [AW-1:0]       ram_wr_addr;
  logic [WordBits-1:0] ram_wr_data;
  logic                ram_rd_en;
  logic [AW-1:0]       ram_rd_addr;
  logic [WordBits-1:0] ram_rd_data;

  // Search datapath signals
  logic [WordBits-1:0]    lo_cut;
  logic [WordBits-1:0]    hi_cut;
  logic [WordBits-1:0]    free_vec;
  logic [NW-1:0]          run_at [WordBits];
  logic [WordBits-1:0]    hit_vec;
  logic [WordIdxBits-1:0] hit_idx;
  logic [NW-1:0]          hit_slot;
  logic [NW-1:0]          hit_start;
  logic [WordBits-1:0]    mark_vec;
  logic [NW-1:0]          cur_ext;
  logic [NW-1:0]          free_end;

  bra_ram #(
    .Width (WordBits),
    .Depth (TotalWords)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (ram_wr_en),
    .wr_addr_i (ram_wr_addr),
    .wr_data_i (ram_wr_data),
    .rd_en_i   (ram_rd_en),
    .rd_addr_i (ram_rd_addr),
    .rd_data_o (ram_rd_data)
  );

  // Run search over one bitmap word: slots outside the scan window count as used
  always_comb begin
    for (int i = 0; i < WordBits; i++) begin
      lo_cut[i] = (eval_q == AW'(cur_q >> WordIdxBits)) &&
                  (WordIdxBits'(i) < cur_q[WordIdxBits-1:0]);
      hi_cut[i] = (eval_q == lim_q) && (rem_of(pool_q) != '0) &&
                  (WordIdxBits'(i) >= rem_of(pool_q));
      free_vec[i] = ram_rd_data[i] && !lo_cut[i] && !hi_cut[i];
    end
    for (int i = 0; i < WordBits; i++) begin
      run_at[i] = run_q + NW'(i + 1);
      for (int j = 0; j <= i; j++) begin
        if (!free_vec[j]) begin
          run_at[i] = NW'(i - j);
        end
      end
      hit_vec[i] = free_vec[i] && (run_at[i] >= NW'(len_q));
    end
    hit_idx = '0;
    for (int i = WordBits - 1; i >= 0; i--) begin
      if (hit_vec[i]) begin
        hit_idx = WordIdxBits'(i);
      end
    end
    hit_slot  = NW'({eval_q, hit_idx});
    hit_start = hit_slot + NW'(1) - NW'(len_q);
  end

  // Slots of the current word that fall in the marked range
  always_comb begin
    for (int i = 0; i < WordBits; i++) begin
      mark_vec[i] = ((eval_q != AW'(start_q >> WordIdxBits)) ||
                     (WordIdxBits'(i) >= start_q[WordIdxBits-1:0])) &&
                    ((eval_q != lim_q) ||
                     (WordIdxBits'(i) <= end_q[WordIdxBits-1:0]));
    end
  end

  assign cur_ext  = NW'(cursor_q[req_i.pool]);
  assign free_end = NW'(req_i.range_start) + NW'(req_i.run_length) - NW'(1);

  // Control sequencer
  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    cursor_d  = cursor_q;
    cmd_d     = cmd_q;
    pool_d    = pool_q;
    len_d     = len_q;
    cur_d     = cur_q;
    run_d     = run_q;
    issue_d   = issue_q;
    iss_on_d  = iss_on_q;
    eval_d    = issue_q;
    vld_d     = 1'b0;
    lim_d     = lim_q;
    start_d   = start_q;
    end_d     = end_q;
    res_d     = res_q;
    out_vld_d = out_vld_q && !out_ready_i;
    out_d     = out_q;
    req_pop_o = 1'b0;

    ram_wr_en   = 1'b0;
    ram_wr_addr = base_of(pool_q) + eval_q;
    ram_wr_data = cmd_q == CMD_FREE ? (ram_rd_data | mark_vec) : (ram_rd_data & ~mark_vec);
    ram_rd_en   = 1'b0;
    ram_rd_addr = base_of(pool_q) + issue_q;

    case (state_q)
      // Set every bitmap word to all free after reset
      S_CLEAR: begin
        ram_wr_en   = 1'b1;
        ram_wr_addr = clr_q;
        ram_wr_data = '1;
        clr_d       = AW'(clr_q + 1'b1);
        if (clr_q == AW'(TotalWords - 1)) begin
          state_d = S_IDLE;
        end
      end

      // Take the next request; reject it or set up its search or marking pass
      S_IDLE: begin
        if (req_valid_i) begin
          req_pop_o = 1'b1;
          cmd_d     = req_i.cmd;
          pool_d    = req_i.pool;
          len_d     = req_i.run_length;
          run_d     = '0;
          iss_on_d  = 1'b1;
          if (req_i.bad_range) begin
            res_d   = '{status: STAT_RANGE, granted_start: '0};
            state_d = S_RESP;
          end else if (req_i.cmd == CMD_ALLOC) begin
            if (NW'(req_i.run_length) > size_of(req_i.pool) - cur_ext) begin
              res_d   = '{status: STAT_NOSPACE, granted_start: '0};
              state_d = S_RESP;
            end else begin
              cur_d   = cursor_q[req_i.pool];
              issue_d = AW'(cursor_q[req_i.pool] >> WordIdxBits);
              lim_d   = last_word_of(req_i.pool);
              state_d = S_SCAN;
            end
          end else begin
            start_d                = SW'(req_i.range_start);
            end_d                  = SW'(free_end);
            cursor_d[req_i.pool]   = SW'(req_i.range_start);
            issue_d                = AW'(req_i.range_start >> WordIdxBits);
            lim_d                  = AW'(free_end >> WordIdxBits);
            res_d                  = '{status: STAT_OK, granted_start: '0};
            state_d                = S_MARK;
          end
        end
      end

      // Stream pool words from the cursor, one word evaluated per cycle
      S_SCAN: begin
        ram_rd_en = iss_on_q;
        vld_d     = iss_on_q;
        issue_d   = AW'(issue_q + 1'b1);
        iss_on_d  = iss_on_q && (issue_q != lim_q);
        if (vld_q) begin
          if (hit_vec != '0) begin
            start_d          = SW'(hit_start);
            end_d            = SW'(hit_slot);
            cursor_d[pool_q] = SW'(hit_slot + NW'(1));
            res_d            = '{status: STAT_OK, granted_start: 10'(hit_start)};
            issue_d          = AW'(hit_start >> WordIdxBits);
            lim_d            = eval_q;
            iss_on_d         = 1'b1;
            vld_d            = 1'b0;
            state_d          = S_MARK;
          end else if (eval_q == lim_q) begin
            res_d   = '{status: STAT_NOSPACE, granted_start: '0};
            vld_d   = 1'b0;
            state_d = S_RESP;
          end else begin
            run_d = run_at[WordBits-1];
          end
        end
      end

      // Read-modify-write of every word touched by the range
      S_MARK: begin
        ram_rd_en = iss_on_q;
        vld_d     = iss_on_q;
        issue_d   = AW'(issue_q + 1'b1);
        iss_on_d  = iss_on_q && (issue_q != lim_q);
        if (vld_q) begin
          ram_wr_en = 1'b1;
          if (eval_q == lim_q) begin
            vld_d   = 1'b0;
            state_d = S_RESP;
          end
        end
      end

      // Hand the result to the output register once it has room
      S_RESP: begin
        if (!out_vld_q || out_ready_i) begin
          out_vld_d = 1'b1;
          out_d     = res_q;
          state_d   = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      clr_q     <= '0;
      iss_on_q  <= 1'b0;
      vld_q     <= 1'b0;
      out_vld_q <= 1'b0;
      for (int p = 0; p < 4; p++) begin
        cursor_q[p] <= '0;
      end
    end else begin
      state_q   <= state_d;
      clr_q     <= clr_d;
      iss_on_q  <= iss_on_d;
      vld_q     <= vld_d;
      out_vld_q <= out_vld_d;
      cursor_q  <= cursor_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    cmd_q   <= cmd_d;
    pool_q  <= pool_d;
    len_q   <= len_d;
    cur_q   <= cur_d;
    run_q   <= run_d;
    issue_q <= issue_d;
    eval_q  <= eval_d;
    lim_q   <= lim_d;
    start_q <= start_d;
    end_q   <= end_d;
    res_q   <= res_d;
    out_q   <= out_d;
  end

  assign clearing_o  = state_q == S_CLEAR;
  assign out_valid_o = out_vld_q;
  assign out_rsp_o   = out_q;

endmodule

`default_nettype wire

>>> hw/rtl/bitmap_run_allocator.sv
// Top level of the bitmap run allocator.
//
// Four pools of slots (view, target, depth, sampler) keep a free bitmap in one
// shared RAM, sixteen slots to a word, and a search cursor each. An allocate
// command looks from the pool's cursor toward the pool's end for the first run
// of run_length free slots, marks it used, moves the cursor past it and returns
// its start; a free command marks a range free and rewinds the cursor to its
// start. After reset the block clears the bitmap RAM one word per cycle, over
// every word of all four pools, and takes no command until that is done. The
// bitmap RAM's single read port sets the pace: an allocate reads the pool's
// words in turn from the cursor word until it finds the run or reaches the
// pool's end, then reads and rewrites each word the granted run spans; a free
// reads and rewrites each word in the range; a rejected command goes straight
// to the result. A two-entry queue takes commands while the engine works, and
// a result register holds each result while the engine moves on to the next
// command.
`default_nettype none

module bitmap_run_allocator #(
  parameter int unsigned VIEW_SLOTS    = 1024,
  parameter int unsigned TARGET_SLOTS  = 256,
  parameter int unsigned DEPTH_SLOTS   = 256,
  parameter int unsigned SAMPLER_SLOTS = 256
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [23:0] s_axis_tdata_i,   // [9:0] range_start, [20:10] run_length
  input  wire logic [2:0]  s_axis_tuser_i,   // [0] command, [2:1] pool
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic      [15:0] m_axis_tdata_o,   // [9:0] granted_start
  output logic      [1:0]  m_axis_tuser_o    // [1:0] status
);

  import bra_pkg::*;

  logic clearing;
  logic q_full;
  logic push;
  req_t push_req;
  logic q_valid;
  req_t q_req;
  logic pop;
  rsp_t out_rsp;

  bra_front #(
    .VIEW_SLOTS    (VIEW_SLOTS),
    .TARGET_SLOTS  (TARGET_SLOTS),
    .DEPTH_SLOTS   (DEPTH_SLOTS),
    .SAMPLER_SLOTS (SAMPLER_SLOTS)
  ) u_front (
    .s_tvalid_i (s_axis_tvalid_i),
    .s_tready_o (s_axis_tready_o),
    .s_tdata_i  (s_axis_tdata_i),
    .s_tuser_i  (s_axis_tuser_i),
    .clearing_i (clearing),
    .q_full_i   (q_full),
    .push_o     (push),
    .req_o      (push_req)
  );

  bra_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .req_i   (push_req),
    .full_o  (q_full),
    .valid_o (q_valid),
    .req_o   (q_req),
    .pop_i   (pop)
  );

  bra_back #(
    .VIEW_SLOTS    (VIEW_SLOTS),
    .TARGET_SLOTS  (TARGET_SLOTS),
    .DEPTH_SLOTS   (DEPTH_SLOTS),
    .SAMPLER_SLOTS (SAMPLER_SLOTS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (q_valid),
    .req_i       (q_req),
    .req_pop_o   (pop),
    .clearing_o  (clearing),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_rsp_o   (out_rsp)
  );

  // Result packing
  assign m_axis_tdata_o = {6'd0, out_rsp.granted_start};
  assign m_axis_tuser_o = out_rsp.status;

endmodule

`default_nettype wire
